### rtl/bldc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bldc_pkg
// Shared constants, types and helpers for the six-step commutation sequencer.
// ----------------------------------------------------------------------------
package bldc_pkg;

  // Alignment sequence timing, in control ticks
  localparam int ALIGN_SWITCH = 20000;
  localparam int ALIGN_END    = 30000;
  localparam int ALIGN_CNT_W  = 15;

  // Back-EMF sample width and divide-by-three by reciprocal multiply
  localparam int SAMPLE_BITS   = 12;
  localparam int BEMF_SUM_W    = SAMPLE_BITS + 2;
  localparam int DIV3_SHIFT    = BEMF_SUM_W + 2;
  localparam int DIV3_RECIP_W  = DIV3_SHIFT - 1;
  localparam int DIV3_RECIP    = (2 ** DIV3_SHIFT + 2) / 3;
  localparam int DIV3_PROD_W   = BEMF_SUM_W + DIV3_RECIP_W;

  // Compare levels
  localparam int LEVEL_W = 7;
  localparam logic [LEVEL_W-1:0] ALIGN_DUTY = LEVEL_W'(50);
  localparam logic [LEVEL_W-1:0] LOW_ON     = LEVEL_W'(100);
  localparam logic [LEVEL_W-1:0] DUTY_MAX   = LEVEL_W'(100);

  // Phase pairs
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PHASE_C_B = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_A_B = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_A_C = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_B_C = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_B_A = 3'd4;
  localparam logic [PHASE_W-1:0] PHASE_C_A = 3'd5;

  // Legs
  localparam logic [1:0] LEG_A = 2'd0;
  localparam logic [1:0] LEG_B = 2'd1;
  localparam logic [1:0] LEG_C = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_LOOP_DUTY    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMMUTATION_DELAY = 8'd1;
  localparam int CFG_DATA_W = 16;

  // Input tick kinds
  localparam logic TICK_CONTROL = 1'b0;
  localparam logic TICK_SAMPLE  = 1'b1;

  // Run modes
  localparam logic RUN_ALIGN = 1'b0;
  localparam logic RUN_OPEN  = 1'b1;

  typedef logic [LEVEL_W-1:0] level_t;

  function automatic logic [1:0] pair_high(input logic [PHASE_W-1:0] p);
    logic [1:0] leg;
    case (p)
      PHASE_C_B: leg = LEG_C;
      PHASE_A_B: leg = LEG_A;
      PHASE_A_C: leg = LEG_A;
      PHASE_B_C: leg = LEG_B;
      PHASE_B_A: leg = LEG_B;
      PHASE_C_A: leg = LEG_C;
      default:   leg = LEG_C;
    endcase
    return leg;
  endfunction

  function automatic logic [1:0] pair_low(input logic [PHASE_W-1:0] p);
    logic [1:0] leg;
    case (p)
      PHASE_C_B: leg = LEG_B;
      PHASE_A_B: leg = LEG_B;
      PHASE_A_C: leg = LEG_C;
      PHASE_B_C: leg = LEG_C;
      PHASE_B_A: leg = LEG_A;
      PHASE_C_A: leg = LEG_A;
      default:   leg = LEG_B;
    endcase
    return leg;
  endfunction

  function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] n;
    if (p >= PHASE_C_A) begin
      n = PHASE_C_B;
    end else begin
      n = p + PHASE_W'(1);
    end
    return n;
  endfunction

endpackage

### rtl/bldc_six_step_commutation.sv
`timescale 1ns / 1ps
// The result register loads from the input register after the input transaction is
// accepted there, once the output is not stalled.
// Throughput: one transaction per cycle unless the output stalls. Once the input register
// holds a transaction, an output stall on a valid result raises in_stall in the same cycle.
// Reset: synchronous, active high; state clears, duty returns to 50, delay to 1.
// ----------------------------------------------------------------------------
// bldc_six_step_commutation
// Six-step commutation sequencer: alignment, open-loop commutation and
// back-EMF averaging, one registered pass per tick.
// ----------------------------------------------------------------------------
module bldc_six_step_commutation (
  input  logic                                   clk,
  input  logic                                   rst,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   mode,
  input  logic [bldc_pkg::SAMPLE_BITS-1:0]       bemf_a,
  input  logic [bldc_pkg::SAMPLE_BITS-1:0]       bemf_b,
  input  logic [bldc_pkg::SAMPLE_BITS-1:0]       bemf_c,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [bldc_pkg::LEVEL_W-1:0]           high_a_level,
  output logic [bldc_pkg::LEVEL_W-1:0]           high_b_level,
  output logic [bldc_pkg::LEVEL_W-1:0]           high_c_level,
  output logic [bldc_pkg::LEVEL_W-1:0]           low_a_level,
  output logic [bldc_pkg::LEVEL_W-1:0]           low_b_level,
  output logic [bldc_pkg::LEVEL_W-1:0]           low_c_level,
  output logic [bldc_pkg::PHASE_W-1:0]           drive_phase,
  output logic                                   run_mode,
  output logic [bldc_pkg::SAMPLE_BITS-1:0]       bemf_mean,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bldc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [bldc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // configuration registers
  logic [bldc_pkg::LEVEL_W-1:0]     open_loop_duty;
  logic [15:0]                      commutation_delay;

  // input register
  logic                             s1_valid;
  logic                             s1_mode;
  logic [bldc_pkg::SAMPLE_BITS-1:0] s1_a;
  logic [bldc_pkg::SAMPLE_BITS-1:0] s1_b;
  logic [bldc_pkg::SAMPLE_BITS-1:0] s1_c;

  // sequencer state; the compare levels, phase, mode and average double as
  // the result register
  logic [bldc_pkg::ALIGN_CNT_W-1:0] align_count;
  logic [15:0]                      tick_count;
  bldc_pkg::level_t                 hi_lvl [3];
  bldc_pkg::level_t                 lo_lvl [3];

  logic [bldc_pkg::ALIGN_CNT_W-1:0] align_count_next;
  logic [15:0]                      tick_count_next;
  bldc_pkg::level_t                 hi_lvl_next [3];
  bldc_pkg::level_t                 lo_lvl_next [3];
  logic [bldc_pkg::PHASE_W-1:0]     drive_phase_next;
  logic                             run_mode_next;
  logic [bldc_pkg::SAMPLE_BITS-1:0] bemf_mean_next;

  logic                             do_drive;
  logic [bldc_pkg::PHASE_W-1:0]     drive_p;
  bldc_pkg::level_t                 drive_duty;
  bldc_pkg::level_t                 duty_sat;
  logic                             delay_hit;
  logic [1:0]                       leg_hi;
  logic [1:0]                       leg_lo;

  logic [bldc_pkg::BEMF_SUM_W-1:0]  bemf_sum;
  logic [bldc_pkg::DIV3_PROD_W-1:0] bemf_prod;

  logic                             out_free;
  logic                             fire;

  assign out_free  = !out_valid || !out_stall;
  assign fire      = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign cfg_ready = 1'b1;

  assign delay_hit = tick_count >= commutation_delay;
  assign duty_sat  = (open_loop_duty > bldc_pkg::DUTY_MAX) ? bldc_pkg::DUTY_MAX
                                                           : open_loop_duty;

  // sum / 3 as a reciprocal multiply; exact for every sum that three samples give
  assign bemf_sum  = bldc_pkg::BEMF_SUM_W'(s1_a) + bldc_pkg::BEMF_SUM_W'(s1_b)
                   + bldc_pkg::BEMF_SUM_W'(s1_c);
  assign bemf_prod = bldc_pkg::DIV3_PROD_W'(bemf_sum)
                   * bldc_pkg::DIV3_PROD_W'(bldc_pkg::DIV3_RECIP);

  always_comb begin
    align_count_next = align_count;
    tick_count_next  = tick_count;
    drive_phase_next = drive_phase;
    run_mode_next    = run_mode;
    bemf_mean_next   = bemf_mean;
    do_drive         = 1'b0;
    drive_p          = bldc_pkg::PHASE_C_B;
    drive_duty       = bldc_pkg::ALIGN_DUTY;

    case (s1_mode)
      bldc_pkg::TICK_CONTROL: begin
        if (run_mode == bldc_pkg::RUN_ALIGN) begin
          if (align_count <= bldc_pkg::ALIGN_CNT_W'(1)) begin
            do_drive         = 1'b1;
            drive_p          = bldc_pkg::PHASE_C_B;
            align_count_next = align_count + bldc_pkg::ALIGN_CNT_W'(1);
          end else if (align_count < bldc_pkg::ALIGN_CNT_W'(bldc_pkg::ALIGN_SWITCH)) begin
            align_count_next = align_count + bldc_pkg::ALIGN_CNT_W'(1);
          end else if (align_count == bldc_pkg::ALIGN_CNT_W'(bldc_pkg::ALIGN_SWITCH)) begin
            do_drive         = 1'b1;
            drive_p          = bldc_pkg::next_phase(drive_phase);
            align_count_next = align_count + bldc_pkg::ALIGN_CNT_W'(1);
          end else if (align_count < bldc_pkg::ALIGN_CNT_W'(bldc_pkg::ALIGN_END)) begin
            align_count_next = align_count + bldc_pkg::ALIGN_CNT_W'(1);
          end else begin
            align_count_next = '0;
            run_mode_next    = bldc_pkg::RUN_OPEN;
          end
        end else if (delay_hit) begin
          do_drive        = 1'b1;
          drive_p         = bldc_pkg::next_phase(drive_phase);
          drive_duty      = duty_sat;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_count + 16'd1;
        end
      end
      bldc_pkg::TICK_SAMPLE: begin
        if (delay_hit) begin
          bemf_mean_next  = bemf_prod[bldc_pkg::DIV3_SHIFT +: bldc_pkg::SAMPLE_BITS];
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_count + 16'd1;
        end
      end
      default: begin
        tick_count_next = tick_count;
      end
    endcase

    leg_hi = bldc_pkg::pair_high(drive_p);
    leg_lo = bldc_pkg::pair_low(drive_p);
    for (int k = 0; k < 3; k++) begin
      if (do_drive) begin
        hi_lvl_next[k] = (leg_hi == 2'(k)) ? drive_duty : '0;
        lo_lvl_next[k] = (leg_lo == 2'(k)) ? bldc_pkg::LOW_ON : '0;
      end else begin
        hi_lvl_next[k] = hi_lvl[k];
        lo_lvl_next[k] = lo_lvl[k];
      end
    end
    if (do_drive) begin
      drive_phase_next = drive_p;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      open_loop_duty    <= bldc_pkg::ALIGN_DUTY;
      commutation_delay <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bldc_pkg::CFG_OPEN_LOOP_DUTY:    open_loop_duty    <= cfg_data[bldc_pkg::LEVEL_W-1:0];
        bldc_pkg::CFG_COMMUTATION_DELAY: commutation_delay <= cfg_data[15:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode <= mode;
      s1_a    <= bemf_a;
      s1_b    <= bemf_b;
      s1_c    <= bemf_c;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      align_count <= '0;
      tick_count  <= '0;
      drive_phase <= bldc_pkg::PHASE_C_B;
      run_mode    <= bldc_pkg::RUN_ALIGN;
      bemf_mean   <= '0;
      for (int k = 0; k < 3; k++) begin
        hi_lvl[k] <= '0;
        lo_lvl[k] <= '0;
      end
    end else begin
      if (fire) begin
        out_valid   <= 1'b1;
        align_count <= align_count_next;
        tick_count  <= tick_count_next;
        drive_phase <= drive_phase_next;
        run_mode    <= run_mode_next;
        bemf_mean   <= bemf_mean_next;
        for (int k = 0; k < 3; k++) begin
          hi_lvl[k] <= hi_lvl_next[k];
          lo_lvl[k] <= lo_lvl_next[k];
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign high_a_level = hi_lvl[0];
  assign high_b_level = hi_lvl[1];
  assign high_c_level = hi_lvl[2];
  assign low_a_level  = lo_lvl[0];
  assign low_b_level  = lo_lvl[1];
  assign low_c_level  = lo_lvl[2];

endmodule

### tb/sv/tb_bldc_six_step_commutation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bldc_six_step_commutation
// Drives control and back-EMF sample ticks through the commutation sequencer,
// predicts every drive state in step with the block and compares each result
// field by field. Covers the full alignment sequence, open-loop commutation
// and back-EMF averaging under several duty and delay settings, with random
// idle cycles and output stalls.
// ----------------------------------------------------------------------------
module tb_bldc_six_step_commutation;
  import bldc_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    level_t                 hi_a;
    level_t                 hi_b;
    level_t                 hi_c;
    level_t                 lo_a;
    level_t                 lo_b;
    level_t                 lo_c;
    logic [PHASE_W-1:0]     pair;
    logic                   running;
    logic [SAMPLE_BITS-1:0] mean;
  } drive_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   mode = TICK_CONTROL;
  logic [SAMPLE_BITS-1:0] bemf_a = '0;
  logic [SAMPLE_BITS-1:0] bemf_b = '0;
  logic [SAMPLE_BITS-1:0] bemf_c = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  level_t                 high_a_level, high_b_level, high_c_level;
  level_t                 low_a_level, low_b_level, low_c_level;
  logic [PHASE_W-1:0]     drive_phase;
  logic                   run_mode;
  logic [SAMPLE_BITS-1:0] bemf_mean;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // sequencer state as the testbench sees it
  level_t                 duty_cfg = ALIGN_DUTY;
  logic [15:0]            delay_cfg = 16'd1;
  logic                   run_q = RUN_ALIGN;
  logic [PHASE_W-1:0]     phase_q = PHASE_C_B;
  logic [ALIGN_CNT_W-1:0] align_cnt = '0;
  logic [15:0]            tick_cnt = '0;
  level_t                 lvl [6] = '{default: '0};
  logic [SAMPLE_BITS-1:0] bemf_avg = '0;

  // high-side and low-side leg of each phase pair
  logic [1:0] high_leg [6] = '{LEG_C, LEG_A, LEG_A, LEG_B, LEG_B, LEG_C};
  logic [1:0] low_leg  [6] = '{LEG_B, LEG_B, LEG_C, LEG_C, LEG_A, LEG_A};

  drive_state_t expected_drive [$];

  bit sender_idle_en = 1'b1;
  bit receiver_idle_en = 1'b1;
  int stall_left = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int n_control = 0, n_sample = 0, n_commute = 0, n_latch = 0, n_cfg = 0;

  bldc_six_step_commutation u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .bemf_a       (bemf_a),
    .bemf_b       (bemf_b),
    .bemf_c       (bemf_c),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .high_a_level (high_a_level),
    .high_b_level (high_b_level),
    .high_c_level (high_c_level),
    .low_a_level  (low_a_level),
    .low_b_level  (low_b_level),
    .low_c_level  (low_c_level),
    .drive_phase  (drive_phase),
    .run_mode     (run_mode),
    .bemf_mean    (bemf_mean),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_drive.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [PHASE_W-1:0] following_pair(input logic [PHASE_W-1:0] p);
    return (p >= PHASE_C_A) ? PHASE_C_B : p + PHASE_W'(1);
  endfunction

  function automatic void drive_pair(input logic [PHASE_W-1:0] p, input level_t duty);
    foreach (lvl[k]) lvl[k] = '0;
    lvl[{1'b0, high_leg[p]}] = duty;
    lvl[3'd3 + {1'b0, low_leg[p]}] = LOW_ON;
    phase_q = p;
  endfunction

  function automatic void align_step();
    if (align_cnt <= 1) begin
      drive_pair(PHASE_C_B, ALIGN_DUTY);
      align_cnt++;
    end else if (align_cnt < ALIGN_SWITCH) begin
      align_cnt++;
    end else if (align_cnt == ALIGN_SWITCH) begin
      drive_pair(following_pair(phase_q), ALIGN_DUTY);
      align_cnt++;
    end else if (align_cnt < ALIGN_END) begin
      align_cnt++;
    end else begin
      align_cnt = '0;
      run_q = RUN_OPEN;
    end
  endfunction

  function automatic drive_state_t advance_sequencer(input logic m,
                                                     input logic [SAMPLE_BITS-1:0] a, b, c);
    drive_state_t r;
    logic [BEMF_SUM_W-1:0] sum;
    level_t duty;
    if (m == TICK_CONTROL) begin
      if (run_q == RUN_ALIGN) begin
        align_step();
      end else if (tick_cnt >= delay_cfg) begin
        duty = (duty_cfg > DUTY_MAX) ? DUTY_MAX : duty_cfg;
        drive_pair(following_pair(phase_q), duty);
        tick_cnt = '0;
        n_commute++;
      end else begin
        tick_cnt++;
      end
    end else begin
      if (tick_cnt >= delay_cfg) begin
        sum = BEMF_SUM_W'(a) + BEMF_SUM_W'(b) + BEMF_SUM_W'(c);
        bemf_avg = SAMPLE_BITS'(sum / 3);
        tick_cnt = '0;
        n_latch++;
      end else begin
        tick_cnt++;
      end
    end
    r.hi_a = lvl[0];
    r.hi_b = lvl[1];
    r.hi_c = lvl[2];
    r.lo_a = lvl[3];
    r.lo_b = lvl[4];
    r.lo_c = lvl[5];
    r.pair = phase_q;
    r.running = run_q;
    r.mean = bemf_avg;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // compare each accepted result with the oldest prediction, then draw a stall
  always @(posedge clk) begin
    drive_state_t e;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_drive.size() == 0) begin
          $error("result transaction with no prediction waiting");
          mismatches++;
        end else begin
          e = expected_drive.pop_front();
          check_field("high_a_level", 16'(e.hi_a), 16'(high_a_level));
          check_field("high_b_level", 16'(e.hi_b), 16'(high_b_level));
          check_field("high_c_level", 16'(e.hi_c), 16'(high_c_level));
          check_field("low_a_level", 16'(e.lo_a), 16'(low_a_level));
          check_field("low_b_level", 16'(e.lo_b), 16'(low_b_level));
          check_field("low_c_level", 16'(e.lo_c), 16'(low_c_level));
          check_field("drive_phase", 16'(e.pair), 16'(drive_phase));
          check_field("run_mode", 16'(e.running), 16'(run_mode));
          check_field("bemf_mean", 16'(e.mean), 16'(bemf_mean));
        end
        stall_left = receiver_idle_en ? $urandom_range(0, 6) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // valid stays high after acceptance; the next call either reloads it or drops it
  task automatic send_tick(input logic m, input logic [SAMPLE_BITS-1:0] a, b, c);
    int gap;
    gap = sender_idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    bemf_a <= a;
    bemf_b <= b;
    bemf_c <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_drive.push_back(advance_sequencer(m, a, b, c));
    if (m == TICK_CONTROL) n_control++;
    else n_sample++;
  endtask

  task automatic send_control();
    send_tick(TICK_CONTROL, pick_sample(), pick_sample(), pick_sample());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_OPEN_LOOP_DUTY) duty_cfg = data[LEVEL_W-1:0];
    else if (idx == CFG_COMMUTATION_DELAY) delay_cfg = data;
    n_cfg++;
  endtask

  // write both registers with an out-of-range write between them; block must be idle
  task automatic set_config(input level_t duty, input logic [15:0] delay);
    write_reg(CFG_OPEN_LOOP_DUTY, {9'($urandom), duty});
    write_reg(CFG_INDEX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
    write_reg(CFG_COMMUTATION_DELAY, delay);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    // reset delay of 1: every second sample transaction latches
    send_tick(TICK_SAMPLE, '0, '0, '0);
    send_tick(TICK_SAMPLE, '1, '1, '1);
    send_control();
    send_control();
    send_tick(TICK_SAMPLE, '1, '0, '0);
    send_tick(TICK_SAMPLE, '1, '0, '0);
  endtask

  task automatic test_alignment();
    int n;
    n = 0;
    while (run_q == RUN_ALIGN) begin
      if (n % 1000 == 0) begin
        sender_idle_en = ($urandom_range(0, 3) != 0);
        receiver_idle_en = ($urandom_range(0, 3) != 0);
      end
      // sample ticks still share the counter while aligning
      if ($urandom_range(0, 63) == 0) send_tick(TICK_SAMPLE, pick_sample(), pick_sample(),
                                                pick_sample());
      else send_control();
      n++;
    end
    sender_idle_en = 1'b1;
    receiver_idle_en = 1'b1;
    // first commutations with the reset duty and delay
    repeat (4) send_control();
    drain();
  endtask

  task automatic test_open_loop_directed();
    set_config(DUTY_MAX, 16'd0);
    repeat (7) send_control();            // full turn and one step more, wraps past C_B
    send_tick(TICK_SAMPLE, '1, '1, '1);
    send_tick(TICK_SAMPLE, '0, '0, '0);
    send_tick(TICK_SAMPLE, 12'd1, 12'd1, 12'd0);
    send_tick(TICK_SAMPLE, '1, '1, 12'd4094);
    drain();
    set_config(7'd127, 16'd0);           // saturates to full duty
    repeat (2) send_control();
    drain();
    set_config(7'd0, 16'hFFFF);
    repeat (4) send_control();
    send_tick(TICK_SAMPLE, pick_sample(), pick_sample(), pick_sample());
    drain();
    // counter is already past the lowered delay: commute at once
    set_config(7'd64, 16'd2);
    send_control();
    send_control();
    drain();
  endtask

  task automatic test_random_traffic();
    level_t duty;
    logic [15:0] delay;
    int sample_pct;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: duty = '0;
        1: duty = DUTY_MAX;
        2: duty = level_t'($urandom_range(101, 127));
        default: duty = level_t'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 3))
        0: delay = 16'd0;
        1: delay = 16'd1;
        2: delay = 16'($urandom_range(2, 6));
        default: delay = 16'($urandom_range(7, 40));
      endcase
      set_config(duty, delay);
      sender_idle_en = ($urandom_range(0, 3) != 0);
      receiver_idle_en = ($urandom_range(0, 3) != 0);
      sample_pct = $urandom_range(10, 70);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < sample_pct) begin
          send_tick(TICK_SAMPLE, pick_sample(), pick_sample(), pick_sample());
        end else begin
          send_control();
        end
      end
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_alignment();
    test_open_loop_directed();
    test_random_traffic();
    drain();
    if (expected_drive.size() != 0) begin
      $error("%0d predicted results never arrived", expected_drive.size());
      mismatches++;
    end
    $display("Run covered %0d control and %0d sample ticks, %0d register writes",
             n_control, n_sample, n_cfg);
    $display("Open loop saw %0d commutations and %0d back-EMF latches, %0d mismatches",
             n_commute, n_latch, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
